>>> hdl/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared widths, action codes and defaults for the window stacking order list.
// ----------------------------------------------------------------------------
package mtf_pkg;

	localparam int ACT_W  = 2;  // action field
	localparam int WIN_W  = 4;  // window index field
	localparam int SLOT_W = 5;  // slot entry: window index plus one, 0 = empty
	localparam int CFG_W  = 5;  // active_slots register

	localparam int MAX_WINDOWS_DEF = 16;

	localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = 5'd16;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MOVE   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

endpackage

>>> hdl/mtf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/move_to_front_window_order_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_window_order_list
// Window stacking order kept as a move-to-front list of slots, front first.
//
// One item is taken at a time. The front slot lives in a register; slots 1 and
// up live in a RAM with registered read data, and every operation that walks
// makes a single walk over the active slots: insert and move walk from the
// bottom up, shifting entries down one place as they go; delete walks from the
// front down and closes the gap behind the window it finds. The walk issues one
// RAM read per cycle. With n the clamped slot count, a move or delete that
// walks reads slots 1 to n-1, then waits for the last read to return, writes
// the tail, loads the result register and goes back to idle; a walking insert
// reads one slot fewer. Operations that touch only the front slot skip the
// walk. The result sits in an output register, so the next item is accepted
// the cycle after the previous result is loaded, even while that result is
// still stalled. active_slots of 0 acts as 1 and values above MAX_WINDOWS act
// as MAX_WINDOWS; slots past the active count keep their contents. After reset
// the list is empty at once (per-entry valid bits, no clearing pass). Write
// cfg_wr_en only while the block is idle.
// ----------------------------------------------------------------------------
module move_to_front_window_order_list #(
	parameter int MAX_WINDOWS = mtf_pkg::MAX_WINDOWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_wr_en,
	input  logic [mtf_pkg::CFG_W-1:0]  cfg_wr_data,

	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [mtf_pkg::ACT_W-1:0]  action,
	input  logic [mtf_pkg::WIN_W-1:0]  window_index,

	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [mtf_pkg::WIN_W-1:0]  front_window,
	output logic                       list_empty,
	output logic                       was_found
);

	localparam int AW = $clog2(MAX_WINDOWS);
	localparam int CW = $clog2(MAX_WINDOWS + 1);
	localparam int SW = mtf_pkg::SLOT_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;  // one RAM read per cycle
	localparam logic [1:0] ST_TAIL = 2'd2;  // closing write, front update
	localparam logic [1:0] ST_DONE = 2'd3;  // load result register

	logic [1:0]                state_q;
	logic [mtf_pkg::CFG_W-1:0] cfg_q;
	logic [SW-1:0]             front_q;
	logic [mtf_pkg::ACT_W-1:0] op_q;
	logic [SW-1:0]             hdl_q;
	logic                      found_q;
	logic                      shift_q;   // entries seen now get moved
	logic                      desc_q;    // walk toward the front
	logic                      iss_q;     // reads still to issue
	logic [AW-1:0]             rd_q;
	logic [AW-1:0]             end_q;
	logic [AW-1:0]             tail_q;    // slot written at the end of a shift
	logic [MAX_WINDOWS-1:0]    valid_q;

	// read return stage
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_addr_s1;
	logic                      last_s1;
	logic                      vbit_s1;

	logic                      res_vld_q;
	logic [mtf_pkg::WIN_W-1:0] res_win_q;
	logic                      res_empty_q;
	logic                      res_found_q;

	logic [CW-1:0]             n_c;
	logic [AW-1:0]             nm1_c;
	logic [AW-1:0]             nm2_c;
	logic [SW-1:0]             hdl_c;
	logic                      accept_c;
	logic                      out_free_c;

	// start decision
	logic                      go_walk_c;
	logic [AW-1:0]             st_rd_c;
	logic [AW-1:0]             st_end_c;
	logic [AW-1:0]             st_tail_c;
	logic                      st_shift_c;
	logic                      st_found_c;
	logic                      st_desc_c;

	logic [SW-1:0]             rdata_raw;
	logic [SW-1:0]             rdata_c;
	logic                      ram_re;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [SW-1:0]             ram_wdata;
	logic                      walk_wr_front_c;  // delete shift into the front slot

	assign item_stall   = (state_q != ST_IDLE);
	assign accept_c     = item_valid && !item_stall;
	assign out_free_c   = !res_vld_q || !result_stall;
	assign result_valid = res_vld_q;
	assign front_window = res_win_q;
	assign list_empty   = res_empty_q;
	assign was_found    = res_found_q;

	// clamp the active slot count into 1..MAX_WINDOWS
	always_comb begin
		if (cfg_q == '0) begin
			n_c = CW'(1);
		end else if (32'(cfg_q) > MAX_WINDOWS) begin
			n_c = CW'(MAX_WINDOWS);
		end else begin
			n_c = CW'(cfg_q);
		end
	end

	assign nm1_c = AW'(n_c - CW'(1));
	assign nm2_c = AW'(n_c - CW'(2));
	assign hdl_c = SW'(window_index) + SW'(1);

	always_comb begin
		go_walk_c  = 1'b0;
		st_rd_c    = '0;
		st_end_c   = AW'(1);
		st_tail_c  = AW'(1);
		st_shift_c = 1'b0;
		st_found_c = 1'b0;
		st_desc_c  = 1'b1;
		case (action)
			mtf_pkg::ACT_INSERT: begin
				// empty front or single slot: just write it; otherwise push everything down
				st_shift_c = (front_q != '0) && (n_c >= CW'(2));
				if (st_shift_c && (n_c >= CW'(3))) begin
					go_walk_c = 1'b1;
					st_rd_c   = nm2_c;
				end
			end
			mtf_pkg::ACT_MOVE: begin
				if (front_q == hdl_c) begin
					st_found_c = 1'b1;
				end else if (n_c >= CW'(2)) begin
					// search from the bottom for the deepest copy
					go_walk_c = 1'b1;
					st_rd_c   = nm1_c;
				end
			end
			mtf_pkg::ACT_DELETE: begin
				st_desc_c  = 1'b0;
				st_tail_c  = nm1_c;
				st_shift_c = (front_q == hdl_c);
				st_found_c = (front_q == hdl_c);
				if (n_c >= CW'(2)) begin
					go_walk_c = 1'b1;
					st_rd_c   = AW'(1);
					st_end_c  = nm1_c;
				end
			end
			default: begin
			end
		endcase
	end

	// slots never written read as empty
	assign rdata_c = vbit_s1 ? rdata_raw : '0;

	assign walk_wr_front_c = !desc_q && (rd_addr_s1 == AW'(1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if ((state_q == ST_WALK) && rd_vld_s1 && shift_q && !walk_wr_front_c) begin
			ram_we    = 1'b1;
			ram_waddr = desc_q ? (rd_addr_s1 + AW'(1)) : (rd_addr_s1 - AW'(1));
			ram_wdata = rdata_c;
		end else if ((state_q == ST_TAIL) && shift_q && (tail_q != '0)) begin
			ram_we    = 1'b1;
			ram_waddr = tail_q;
			ram_wdata = desc_q ? front_q : '0;
		end
	end

	assign ram_re = (state_q == ST_WALK) && iss_q;

	mtf_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_WINDOWS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_q),
		.rdata (rdata_raw)
	);

	// payload of the read stage and the result register
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_q;
		last_s1    <= (rd_q == end_q);
		vbit_s1    <= valid_q[rd_q];
		if (accept_c) begin
			op_q  <= action;
			hdl_q <= hdl_c;
		end
		if ((state_q == ST_DONE) && out_free_c) begin
			res_win_q   <= (front_q == '0) ? '0 :
				mtf_pkg::WIN_W'(front_q - SW'(1));
			res_empty_q <= (front_q == '0);
			res_found_q <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cfg_q     <= mtf_pkg::ACTIVE_SLOTS_RST;
			front_q   <= '0;
			valid_q   <= '0;
			found_q   <= 1'b0;
			shift_q   <= 1'b0;
			desc_q    <= 1'b1;
			iss_q     <= 1'b0;
			rd_q      <= '0;
			end_q     <= '0;
			tail_q    <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			// a new result replaces the one leaving in the same cycle
			if ((state_q == ST_DONE) && out_free_c) begin
				res_vld_q <= 1'b1;
			end else if (res_vld_q && !result_stall) begin
				res_vld_q <= 1'b0;
			end
			rd_vld_s1 <= ram_re;

			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						found_q <= st_found_c;
						shift_q <= st_shift_c;
						desc_q  <= st_desc_c;
						iss_q   <= go_walk_c;
						rd_q    <= st_rd_c;
						end_q   <= st_end_c;
						tail_q  <= st_tail_c;
						state_q <= go_walk_c ? ST_WALK : ST_TAIL;
					end
				end
				ST_WALK: begin
					if (iss_q) begin
						iss_q <= (rd_q != end_q);
						rd_q  <= desc_q ? (rd_q - AW'(1)) : (rd_q + AW'(1));
					end
					if (rd_vld_s1) begin
						if (shift_q) begin
							if (walk_wr_front_c) begin
								front_q <= rdata_c;
							end
						end else if (rdata_c == hdl_q) begin
							// hit: this entry is dropped, later ones move
							shift_q <= 1'b1;
							found_q <= 1'b1;
						end
						if (last_s1) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					if ((op_q == mtf_pkg::ACT_INSERT) || (op_q == mtf_pkg::ACT_MOVE)) begin
						front_q <= hdl_q;
					end else if ((op_q == mtf_pkg::ACT_DELETE) && shift_q &&
					             (tail_q == '0)) begin
						front_q <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/mtf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_checker
// Port-level checks for the window stacking order list, bound to the top.
// ----------------------------------------------------------------------------
module mtf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_stall,
	input logic [mtf_pkg::ACT_W-1:0] action,
	input logic [mtf_pkg::WIN_W-1:0] window_index,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic [mtf_pkg::WIN_W-1:0] front_window,
	input logic                      list_empty,
	input logic                      was_found
);

	// outstanding items, oldest in entry 0
	logic [1:0]                cnt_q;
	logic [mtf_pkg::ACT_W-1:0] act0_q;
	logic [mtf_pkg::ACT_W-1:0] act1_q;
	logic [mtf_pkg::WIN_W-1:0] win0_q;
	logic [mtf_pkg::WIN_W-1:0] win1_q;
	logic                      push;
	logic                      pop;
	logic                      push0;   // new item lands in entry 0

	assign push  = item_valid && !item_stall;
	assign pop   = result_valid && !result_stall;
	assign push0 = push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));

	always_ff @(posedge clk) begin
		if (push0) begin
			act0_q <= action;
			win0_q <= window_index;
		end else if (pop) begin
			act0_q <= act1_q;
			win0_q <= win1_q;
		end
		if (push && !push0) begin
			act1_q <= action;
			win1_q <= window_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(front_window) &&
		$stable(list_empty) && $stable(was_found))
		else $error("stalled result changed");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != 2'd0)
		else $error("result without an item");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt_q != 2'd2)
		else $error("item taken while another is in work");

	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (cnt_q != 2'd0) &&
		((act0_q == mtf_pkg::ACT_INSERT) || (act0_q == mtf_pkg::ACT_MOVE))
		|-> !list_empty && (front_window == win0_q))
		else $error("window not at front after insert or move");

	a_insert_nf: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (cnt_q != 2'd0) && (act0_q == mtf_pkg::ACT_INSERT)
		|-> !was_found)
		else $error("insert reported found");

endmodule

bind move_to_front_window_order_list mtf_checker u_mtf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.action       (action),
	.window_index (window_index),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.front_window (front_window),
	.list_empty   (list_empty),
	.was_found    (was_found)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the window stacking order list.
//
// Window events (insert, move to front, delete, and the spare action code)
// are queued by the stimulus process and then issued by a clocked driver.
// When the block accepts an event, the bench replays it on its own copy of
// the slot list and records the front of the list that should come back.
// A clocked monitor compares each returned beat, field by field, with the
// oldest recorded front. The run steps through a series of active_slots
// settings, the extremes among them. It has three idle patterns and one long
// output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ACT_W  = mtf_pkg::ACT_W;
	localparam int WIN_W  = mtf_pkg::WIN_W;
	localparam int SLOT_W = mtf_pkg::SLOT_W;
	localparam int CFG_W  = mtf_pkg::CFG_W;

	localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RST = mtf_pkg::ACTIVE_SLOTS_RST;

	localparam logic [ACT_W-1:0] ACT_INSERT = mtf_pkg::ACT_INSERT;
	localparam logic [ACT_W-1:0] ACT_MOVE   = mtf_pkg::ACT_MOVE;
	localparam logic [ACT_W-1:0] ACT_DELETE = mtf_pkg::ACT_DELETE;

	// spare action encoding: the block must leave the list alone
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	localparam int SLOTS       = mtf_pkg::MAX_WINDOWS_DEF;
	localparam int DRAIN_WAIT  = 32;   // longer than the worst walk
	localparam int HOLD_CYCLES = 300;  // long output stall
	localparam int NUM_PHASES  = 12;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [WIN_W-1:0] win;
	} window_event_t;

	typedef struct packed {
		logic [WIN_W-1:0] front;
		logic             empty;
		logic             found;
	} front_info_t;

	// ------------------------------------------------------------------
	// clock, reset, block inputs (all known from time zero)
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_wr_en    = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data  = '0;
	logic              item_valid   = 1'b0;
	logic [ACT_W-1:0]  action       = ACT_INSERT;
	logic [WIN_W-1:0]  window_index = '0;
	logic              result_stall = 1'b0;

	logic              item_stall;
	logic              result_valid;
	logic [WIN_W-1:0]  front_window;
	logic              list_empty;
	logic              was_found;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	move_to_front_window_order_list dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.window_index (window_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.front_window (front_window),
		.list_empty   (list_empty),
		.was_found    (was_found)
	);

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	window_event_t     pending_events[$];      // filled by stimulus, drained by driver
	front_info_t       front_expectations[$];  // one per accepted event, oldest first

	// shadow of the block: slot list (window + 1, 0 = empty) and register
	logic [SLOT_W-1:0] stack_order[SLOTS];
	logic [CFG_W-1:0]  active_slots_cfg = ACTIVE_SLOTS_RST;

	int unsigned send_gap_pct = 12;
	int unsigned recv_gap_pct = 50;
	logic        long_hold    = 1'b0;
	bit          hold_go      = 1'b0;

	int unsigned mismatch_cnt   = 0;
	int unsigned results_seen   = 0;
	int unsigned hit_cnt        = 0;
	int unsigned held_off_beats = 0;   // cycles the block pushed back on input
	int unsigned settings_used  = 1;
	int unsigned action_cnt[4]  = '{default: 0};

	// ------------------------------------------------------------------
	// predictor: apply one window event to the shadow list and return the
	// front of the list that the block should report afterwards
	// ------------------------------------------------------------------
	function automatic front_info_t apply_window_event(input logic [ACT_W-1:0] act,
	                                                   input logic [WIN_W-1:0] win);
		logic [SLOT_W-1:0] tag;
		int                n;
		int                pos;
		int                i;
		front_info_t       r;
		tag     = {1'b0, win} + 1'b1;
		// register value 0 behaves as one slot, anything past SLOTS as SLOTS
		n       = (active_slots_cfg == 0) ? 1 :
		          (active_slots_cfg > SLOTS) ? SLOTS : int'(active_slots_cfg);
		r.found = 1'b0;
		case (act)
			ACT_INSERT: begin
				// no duplicate check; nothing shifts while the front is empty
				if (stack_order[0] != '0) begin
					for (i = n - 1; i > 0; i--)
						stack_order[i] = stack_order[i - 1];
				end
				stack_order[0] = tag;
			end
			ACT_MOVE: begin
				if (stack_order[0] == tag) begin
					r.found = 1'b1;
				end else begin
					// search from the bottom: with duplicates the lowest copy moves
					pos = 0;
					for (i = n - 1; i > 0; i--) begin
						if (stack_order[i] == tag) begin
							pos = i;
							break;
						end
					end
					// absent window: pos stays 0 and the front slot is overwritten
					for (i = pos; i > 0; i--)
						stack_order[i] = stack_order[i - 1];
					stack_order[0] = tag;
					r.found = (pos != 0);
				end
			end
			ACT_DELETE: begin
				pos = n;
				for (i = 0; i < n; i++) begin
					if (stack_order[i] == tag) begin
						pos = i;
						break;
					end
				end
				if (pos < n) begin
					for (i = pos; i + 1 < n; i++)
						stack_order[i] = stack_order[i + 1];
					stack_order[n - 1] = '0;
					r.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.empty = (stack_order[0] == '0);
		r.front = r.empty ? '0 : WIN_W'(stack_order[0] - 1'b1);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// driver: one beat in flight at a time, held while stalled
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_stall)
				held_off_beats++;
			if (item_valid && !item_stall) begin
				front_expectations.push_back(apply_window_event(action, window_index));
				action_cnt[action]++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					window_event_t ev;
					ev = pending_events.pop_front();
					item_valid   <= 1'b1;
					action       <= ev.act;
					window_index <= ev.win;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: compare each result beat with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (front_expectations.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: unexpected result beat front=%0d empty=%0b found=%0b",
						         $time, front_window, list_empty, was_found);
				end else begin
					front_info_t want;
					want = front_expectations.pop_front();
					results_seen++;
					if (was_found === 1'b1)
						hit_cnt++;
					if (front_window !== want.front || list_empty !== want.empty ||
					    was_found !== want.found) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$display("%0t: result %0d exp front=%0d empty=%0b found=%0b",
							         $time, results_seen, want.front, want.empty,
							         want.found);
							$display("%0t: result %0d got front=%0d empty=%0b found=%0b",
							         $time, results_seen, front_window, list_empty,
							         was_found);
						end
					end
				end
			end
			result_stall <= long_hold || ($urandom_range(99) < recv_gap_pct);
		end
	end

	// ------------------------------------------------------------------
	// long output stall, counted here; the sender keeps offering beats so
	// the output register fills and the block stalls its input
	// ------------------------------------------------------------------
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// run limit
	initial begin
		#1000000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic queue_event(input logic [ACT_W-1:0] act, input logic [WIN_W-1:0] win);
		window_event_t ev;
		ev.act = act;
		ev.win = win;
		pending_events.push_back(ev);
	endtask

	// sampled at the falling edge so driver updates from the last edge are settled
	task automatic wait_until_idle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || item_valid || front_expectations.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_active_slots(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en        <= 1'b0;
		active_slots_cfg = v;
		settings_used++;
	endtask

	initial begin
		logic [CFG_W-1:0] phase_cfg[NUM_PHASES];
		logic [WIN_W-1:0] hot_wins[6];
		int               hot_n;
		int               count;
		int unsigned      pick;
		logic [ACT_W-1:0] act;
		logic [WIN_W-1:0] win;

		// mix of extremes, mid values and out-of-range settings
		phase_cfg =
			'{5'd4, 5'd0, 5'd31, 5'd16, 5'd2, 5'd9, 5'd17, 5'd1, 5'd12, 5'd16, 5'd5, 5'd24};

		foreach (stack_order[k])
			stack_order[k] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset setting of 16 slots
		queue_event(ACT_DELETE, 4'd5);    // delete on empty list
		queue_event(ACT_NONE,   4'd0);    // spare code on empty list
		queue_event(ACT_MOVE,   4'd9);    // move absent into empty front
		queue_event(ACT_INSERT, 4'd0);
		queue_event(ACT_INSERT, 4'd15);
		queue_event(ACT_INSERT, 4'd15);   // duplicate
		queue_event(ACT_MOVE,   4'd15);   // already at front
		queue_event(ACT_MOVE,   4'd0);    // found deeper in list
		queue_event(ACT_MOVE,   4'd7);    // absent: overwrites front
		queue_event(ACT_NONE,   4'd15);
		queue_event(ACT_DELETE, 4'd15);   // removes upper copy only
		queue_event(ACT_DELETE, 4'd10);   // absent, list unchanged
		queue_event(ACT_DELETE, 4'd9);    // bottom of list
		queue_event(ACT_DELETE, 4'd7);
		queue_event(ACT_DELETE, 4'd0);    // absent, window 15 stays
		wait_until_idle();

		// directed, single slot: inserts drop the old front
		write_active_slots(5'd1);
		queue_event(ACT_INSERT, 4'd3);
		queue_event(ACT_INSERT, 4'd12);
		queue_event(ACT_MOVE,   4'd12);
		queue_event(ACT_MOVE,   4'd3);
		queue_event(ACT_DELETE, 4'd12);
		queue_event(ACT_DELETE, 4'd3);
		queue_event(ACT_INSERT, 4'd6);
		wait_until_idle();

		// random phases: each picks a small hot set so moves and deletes hit
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_active_slots(phase_cfg[p]);
			if (p < 4) begin
				send_gap_pct = 12;
				recv_gap_pct = 50;
			end else if (p < 8) begin
				send_gap_pct = 50;
				recv_gap_pct = 12;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			hot_n = $urandom_range(6, 2);
			for (int h = 0; h < 6; h++)
				hot_wins[h] = WIN_W'($urandom_range(15));
			count = 130 + $urandom_range(12);
			for (int j = 0; j < count; j++) begin
				pick = $urandom_range(99);
				act  = (pick < 35) ? ACT_INSERT :
				       (pick < 65) ? ACT_MOVE   :
				       (pick < 95) ? ACT_DELETE : ACT_NONE;
				win  = ($urandom_range(99) < 70) ? hot_wins[$urandom_range(hot_n - 1)] :
				                                   WIN_W'($urandom_range(15));
				queue_event(act, win);
			end
			if (p == 2)
				hold_go = 1'b1;
			wait_until_idle();
		end

		if (front_expectations.size() != 0) begin
			mismatch_cnt++;
			$display("%0d expected results never arrived", front_expectations.size());
		end
		$display("covered %0d beats over %0d slot settings, input held off for %0d cycles",
		         results_seen, settings_used, held_off_beats);
		$display("insert %0d, move %0d, delete %0d, spare %0d; windows found %0d times",
		         action_cnt[ACT_INSERT], action_cnt[ACT_MOVE], action_cnt[ACT_DELETE],
		         action_cnt[ACT_NONE], hit_cnt);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
